/* sv/bfa_pkg.sv */
package bfa_pkg;

  // Geometry of the frame map
  localparam int unsigned MAP_WORDS     = 512;
  localparam int unsigned MAX_FRAMES    = 16384;
  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned FRAME_SHIFT   = 12;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned LOW_MEM_LIMIT = 32'h0010_0000;
  localparam int unsigned MEM_CAP       = 64 * 1024 * 1024;

  localparam int unsigned WADDR_W = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W   = $clog2(WORD_BITS);
  localparam int unsigned FRAME_W = ADDR_W - FRAME_SHIFT;

  // Largest frame count that init can set
  localparam int unsigned MAP_CAP    = MAP_WORDS * WORD_BITS;
  localparam int unsigned SIZE_CAP   = MEM_CAP >> FRAME_SHIFT;
  localparam int unsigned CAP_0      = (MAP_CAP < MAX_FRAMES) ? MAP_CAP : MAX_FRAMES;
  localparam int unsigned CAP_FRAMES = (SIZE_CAP < CAP_0) ? SIZE_CAP : CAP_0;
  localparam int unsigned FCNT_W     = $clog2(CAP_FRAMES + 1);
  localparam int unsigned NWORDS_W   = $clog2(MAP_WORDS + 1);

  // Words fully covered by the low 1 MiB
  localparam int unsigned LOW_WORDS = (LOW_MEM_LIMIT >> FRAME_SHIFT) / WORD_BITS;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned CIDX_W = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MEM_SIZE = 2'd0,
    CFG_KSTART   = 2'd1,
    CFG_KEND     = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_PREP,
    S_INIT_WR,
    S_ALLOC,
    S_FREE_WR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    UM_INIT,
    UM_ALLOC,
    UM_FREE
  } unit_mode_t;

  // Request to the shared word unit
  typedef struct packed {
    unit_mode_t           mode;
    logic [WADDR_W-1:0]   word;
    logic [FRAME_W-1:0]   lo;
    logic [FCNT_W-1:0]    hi;
    logic [BIT_W-1:0]     bit_sel;
    word_t                data;
  } unit_req_t;

  // Answer of the shared word unit
  typedef struct packed {
    word_t              word;
    logic               hit;
    logic [BIT_W-1:0]   idx;
  } unit_rsp_t;

  // Map RAM port controls
  typedef struct packed {
    logic [WADDR_W-1:0] rd_addr;
    logic               we;
    logic [WADDR_W-1:0] wr_addr;
    word_t              wr_data;
  } ram_req_t;

  // Configuration values seen by the sequencer
  typedef struct packed {
    addr_t mem_size;
    addr_t kstart;
    addr_t kend;
  } cfg_t;

endpackage

/* sv/bfa_ifs.sv */
// Request channel into the allocator
interface bfa_in_if;
  import bfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  addr_t             free_addr;
  modport source (output valid, output op, output free_addr, input ready);
  modport sink   (input valid, input op, input free_addr, output ready);
endinterface

// Result channel out of the allocator
interface bfa_out_if;
  import bfa_pkg::*;
  logic  valid;
  logic  ready;
  addr_t frame_addr;
  modport source (output valid, output frame_addr, input ready);
  modport sink   (input valid, input frame_addr, output ready);
endinterface

// Configuration write channel
interface bfa_cfg_if;
  import bfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  addr_t             data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/bfa_map_ram.sv */
module bfa_map_ram (
  input  logic             clk,
  input  bfa_pkg::ram_req_t req,
  output bfa_pkg::word_t   rd_data
);
  import bfa_pkg::*;

  // Used map, one bit per frame; init rewrites every word before any read matters
  word_t mem [MAP_WORDS];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/bfa_word_unit.sv */
module bfa_word_unit (
  input  bfa_pkg::unit_req_t req,
  output bfa_pkg::unit_rsp_t rsp
);
  import bfa_pkg::*;

  localparam int unsigned LOW_W = FRAME_W - BIT_W;
  localparam int unsigned HIW_W = FCNT_W - BIT_W;

  logic [LOW_W-1:0] lo_word;
  logic [LOW_W-1:0] w_lo;
  logic [HIW_W-1:0] hi_word;
  logic [HIW_W-1:0] w_hi;
  word_t            ge_mask;
  word_t            lt_mask;
  word_t            range_mask;
  word_t            free_bits;
  word_t            lowest;
  logic [BIT_W-1:0] idx;

  assign lo_word = req.lo[FRAME_W-1:BIT_W];
  assign hi_word = req.hi[FCNT_W-1:BIT_W];
  assign w_lo    = LOW_W'(req.word);
  assign w_hi    = HIW_W'(req.word);

  // Bits of this word with frame number at or above lo
  always_comb begin
    if (w_lo > lo_word) begin
      ge_mask = '1;
    end else if (w_lo == lo_word) begin
      ge_mask = '1 << req.lo[BIT_W-1:0];
    end else begin
      ge_mask = '0;
    end
  end

  // Bits of this word with frame number below hi
  always_comb begin
    if (w_hi < hi_word) begin
      lt_mask = '1;
    end else if (w_hi == hi_word) begin
      lt_mask = ~('1 << req.hi[BIT_W-1:0]);
    end else begin
      lt_mask = '0;
    end
  end

  assign range_mask = ge_mask & lt_mask;

  // Lowest free bit inside the range: isolate, then encode
  assign free_bits = ~req.data & range_mask;
  assign lowest    = free_bits & (~free_bits + word_t'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
  end

  // Word to write back per mode
  always_comb begin
    rsp.hit = |free_bits;
    rsp.idx = idx;
    unique case (req.mode)
      UM_INIT: begin
        rsp.word = (32'(req.word) < LOW_WORDS) ? '1 : range_mask;
      end
      UM_ALLOC: begin
        rsp.word = req.data | lowest;
      end
      UM_FREE: begin
        rsp.word = req.data & ~(word_t'(1) << req.bit_sel);
      end
      default: begin
        rsp.word = req.data;
      end
    endcase
  end

endmodule

/* sv/bfa_ctrl.sv */
module bfa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfa_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [bfa_pkg::OP_W-1:0] in_op,
  input  bfa_pkg::addr_t        in_free_addr,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bfa_pkg::addr_t        out_frame_addr,
  output bfa_pkg::ram_req_t     ram_req,
  input  bfa_pkg::word_t        ram_rd_data,
  output bfa_pkg::unit_req_t    unit_req,
  input  bfa_pkg::unit_rsp_t    unit_rsp
);
  import bfa_pkg::*;

  localparam int unsigned RES_PAD = ADDR_W - WADDR_W - BIT_W - FRAME_SHIFT;

  state_t             state_r, state_nxt;
  logic [WADDR_W-1:0] w_r, w_nxt;
  logic [BIT_W-1:0]   b_r, b_nxt;
  logic [FCNT_W-1:0]  fc_r, fc_nxt;
  logic [FRAME_W-1:0] lo_r, lo_nxt;
  logic [FCNT_W-1:0]  hi_r, hi_nxt;
  addr_t              res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  addr_t              out_addr_r, out_addr_nxt;

  logic               accept;
  op_t                op;
  logic [FRAME_W-1:0] size_frames;
  logic [FCNT_W-1:0]  n_frames;
  logic [FRAME_W:0]   last_frame;
  logic [FCNT_W-1:0]  hi_calc;
  logic [FRAME_W-1:0] free_frame;
  logic               free_ok;
  logic [NWORDS_W-1:0] scan_words;
  logic [NWORDS_W-1:0] w_next_cnt;
  logic               slot_free;
  logic               last_word;

  assign accept    = in_valid && in_ready;
  assign op        = op_t'(in_op);
  assign slot_free = !out_valid_r || out_ready;

  // Frame count and kernel range for init
  assign size_frames = cfg.mem_size[ADDR_W-1:FRAME_SHIFT];
  assign n_frames    = (size_frames > FRAME_W'(CAP_FRAMES)) ? FCNT_W'(CAP_FRAMES)
                                                            : size_frames[FCNT_W-1:0];
  assign last_frame  = {1'b0, cfg.kend[ADDR_W-1:FRAME_SHIFT]}
                     + (FRAME_W+1)'(cfg.kend[FRAME_SHIFT-1:0] != '0);
  assign hi_calc     = (last_frame > (FRAME_W+1)'(n_frames)) ? n_frames
                                                             : last_frame[FCNT_W-1:0];

  // Free request checks
  assign free_frame = in_free_addr[ADDR_W-1:FRAME_SHIFT];
  assign free_ok    = (in_free_addr[FRAME_SHIFT-1:0] == '0) && (free_frame != '0)
                   && (free_frame < FRAME_W'(fc_r));

  // Words that hold managed frames
  assign scan_words = NWORDS_W'((({1'b0, fc_r}) + (FCNT_W+1)'(WORD_BITS - 1)) >> BIT_W);
  assign w_next_cnt = NWORDS_W'(w_r) + NWORDS_W'(1);
  assign last_word  = (w_r == WADDR_W'(MAP_WORDS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INIT:  state_nxt = S_INIT_PREP;
            OP_ALLOC: state_nxt = S_ALLOC;
            OP_FREE:  state_nxt = free_ok ? S_FREE_WR : S_DONE;
            OP_NONE:  state_nxt = S_DONE;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_INIT_PREP: state_nxt = S_INIT_WR;
      S_INIT_WR: begin
        if (last_word) begin
          state_nxt = S_DONE;
        end
      end
      S_ALLOC: begin
        if (unit_rsp.hit || (w_next_cnt >= scan_words)) begin
          state_nxt = S_DONE;
        end
      end
      S_FREE_WR: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath controls and register updates
  always_comb begin
    w_nxt         = w_r;
    b_nxt         = b_r;
    fc_nxt        = fc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    in_ready      = 1'b0;

    ram_req.rd_addr = w_r;
    ram_req.we      = 1'b0;
    ram_req.wr_addr = w_r;
    ram_req.wr_data = unit_rsp.word;

    unit_req.mode    = UM_ALLOC;
    unit_req.word    = w_r;
    unit_req.lo      = '0;
    unit_req.hi      = fc_r;
    unit_req.bit_sel = b_r;
    unit_req.data    = ram_rd_data;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        res_nxt  = '0;
        if (accept) begin
          if (op == OP_FREE) begin
            w_nxt           = free_frame[WADDR_W+BIT_W-1:BIT_W];
            b_nxt           = free_frame[BIT_W-1:0];
            ram_req.rd_addr = free_frame[WADDR_W+BIT_W-1:BIT_W];
          end else begin
            w_nxt           = '0;
            ram_req.rd_addr = '0;
          end
        end
      end
      S_INIT_PREP: begin
        fc_nxt = n_frames;
        lo_nxt = cfg.kstart[ADDR_W-1:FRAME_SHIFT];
        hi_nxt = hi_calc;
        w_nxt  = '0;
      end
      S_INIT_WR: begin
        unit_req.mode = UM_INIT;
        unit_req.lo   = lo_r;
        unit_req.hi   = hi_r;
        ram_req.we    = 1'b1;
        w_nxt         = w_r + WADDR_W'(1);
      end
      S_ALLOC: begin
        // scan one word per cycle, next word already being read
        ram_req.rd_addr = w_r + WADDR_W'(1);
        if (unit_rsp.hit) begin
          ram_req.we = 1'b1;
          res_nxt    = {{RES_PAD{1'b0}}, w_r, unit_rsp.idx, {FRAME_SHIFT{1'b0}}};
        end else begin
          w_nxt = w_r + WADDR_W'(1);
        end
      end
      S_FREE_WR: begin
        unit_req.mode = UM_FREE;
        ram_req.we    = 1'b1;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    b_r        <= b_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    res_r      <= res_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_addr = out_addr_r;

endmodule

/* sv/bitmap_frame_allocator.sv */
// Channel   Port     Direction  Payload
// request   in_ch    sink       op, free_addr
// result    out_ch   source     frame_addr
// config    cfg_ch   sink       index, data (always ready)
//
// Init has a setup state, then writes one map word per cycle. Alloc scans one
// word per cycle, up to the last word that holds managed frames, through the
// shared word unit and the map RAM read port. Free clears the frame's bit in its
// map word; a rejected address or an unused op goes straight to the done state.
// Reset is synchronous; the map needs no clearing pass, since init rewrites it.
// A finished result waits in the output register; a stalled out_ch holds the
// sequencer in its done state and the next request waits.
module bitmap_frame_allocator (
  input logic      clk,
  input logic      rst_n,
  bfa_in_if.sink   in_ch,
  bfa_out_if.source out_ch,
  bfa_cfg_if.sink  cfg_ch
);
  import bfa_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  ram_req_t  ram_req;
  word_t     ram_rd_data;
  unit_req_t unit_req;
  unit_rsp_t unit_rsp;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_MEM_SIZE: cfg_nxt.mem_size = cfg_ch.data;
        CFG_KSTART:   cfg_nxt.kstart   = cfg_ch.data;
        CFG_KEND:     cfg_nxt.kend     = cfg_ch.data;
        CFG_UNUSED:   cfg_nxt          = cfg_r;
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bfa_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_op          (in_ch.op),
    .in_free_addr   (in_ch.free_addr),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_frame_addr (out_ch.frame_addr),
    .ram_req        (ram_req),
    .ram_rd_data    (ram_rd_data),
    .unit_req       (unit_req),
    .unit_rsp       (unit_rsp)
  );

  bfa_word_unit u_unit (
    .req (unit_req),
    .rsp (unit_rsp)
  );

  bfa_map_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule
